// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the wavetable mixer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCWM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcwm assertion failed");
`define FCWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcwm assertion failed");
`else
`define FCWM_ASSERT_SAME(label, clk, rst, ante, cons)
`define FCWM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/fcwm_pkg.sv =====
// Types and constants of the four-channel wavetable mixer.
`default_nettype none
package fcwm_pkg;

   localparam int WAVE_STEPS = 32;
   localparam int IDX_W      = 5;
   localparam int PHASE_W    = 23;
   localparam int DVD_W      = PHASE_W + 8;
   localparam int DIVR_W     = 12;
   localparam int DCNT_W     = $clog2(DVD_W);
   localparam int FREQ_W     = 11;
   localparam int ACC_W      = 12;
   localparam int CSR_IDX_W  = 3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_FREQ0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FREQ1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FREQ2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FREQ3   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_VOLUMES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CHAN_EN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MODE    = 3'd6;

   localparam int MODE_VOICE_EN   = 4;
   localparam int MODE_SWEEP_KEEP = 5;
   localparam int MODE_VOICE_MODE = 6;
   localparam int MODE_SWEEP_MODE = 7;

   localparam logic [7:0] MODE_RESET  = 8'd63;
   localparam logic [7:0] WAVE_RESET  = 8'h88;
   localparam logic [DIVR_W-1:0] PERIOD_BASE = 12'd2048;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_READ,
      ST_ACC,
      ST_MIX,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] quot;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== hdl/four_channel_wavetable_mixer_unit.sv =====
// Top level of the wavetable mixer: registers, channel sequencer, mixer and output stage.
//
//   Channel  Direction  Words per item        Purpose
//   req_     in         1                     wave RAM write or sample tick
//   rsp_     out        0 (write), 5 or 4     mixed sample copies, last on final copy
//   csr_     in         1 per register write  frequency, volume, enable and mode registers
//
// A write word leaves the unit idle. A tick checks each channel in turn: a sounding channel
// is divided in the shared divider, read and accumulated, a silent one is only checked; then the mix and the copies.
// The divider works out one quotient bit a cycle for each sounding channel.
// Reset is synchronous; the wave RAM needs no clearing pass, unwritten rows read as 8'h88 (each sample 8).
// req_ready is low from an accepted tick until its final copy is taken; rsp_ready stalls hold.
`default_nettype none
`include "assert_macros.svh"
module four_channel_wavetable_mixer_unit import fcwm_pkg::*; #(
   parameter int CHANNELS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_type,
   input  wire logic [5:0]           req_wave_addr,
   input  wire logic [7:0]           req_wave_byte,
   input  wire logic [7:0]           req_voice_sample,
   input  wire logic [7:0]           req_hyper_sample,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [15:0]               rsp_mixed_sample,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = CHANNELS * (WAVE_STEPS / 2);
   localparam int AW    = CH_W + 4;

   logic [FREQ_W-1:0] freq_ff [4];
   logic [31:0]       volumes_ff;
   logic [3:0]        chan_en_ff;
   logic [7:0]        mode_ff;

   state_type         state_ff, state_in;
   logic [CH_W-1:0]   chan_ff, chan_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [PHASE_W-1:0] phase_ff [CHANNELS];
   logic [PHASE_W-1:0] phase_in [CHANNELS];
   logic [IDX_W-1:0]  prev_ff [CHANNELS];
   logic [IDX_W-1:0]  prev_in [CHANNELS];
   logic              toggle_ff, toggle_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [15:0]       mixed_ff, mixed_in;
   logic              rsp_valid_ff, rsp_valid_in;

   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic [2:0]        chan3;
   logic [1:0]        c2;
   logic              plays;
   logic              last_chan;
   logic [3:0]        nibble;
   logic [3:0]        vol;
   logic signed [4:0] value;
   logic signed [9:0] prod;
   logic signed [ACC_W-1:0] voice_term;
   logic signed [ACC_W-1:0] hyper_term;
   logic signed [ACC_W-1:0] total;
   logic [15:0]       total16;
   logic              req_fire;
   logic              rsp_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            freq_ff[i] <= '0;
         end
         volumes_ff <= '0;
         chan_en_ff <= '0;
         mode_ff    <= MODE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FREQ0:   freq_ff[0] <= csr_wdata[FREQ_W-1:0];
            REG_FREQ1:   freq_ff[1] <= csr_wdata[FREQ_W-1:0];
            REG_FREQ2:   freq_ff[2] <= csr_wdata[FREQ_W-1:0];
            REG_FREQ3:   freq_ff[3] <= csr_wdata[FREQ_W-1:0];
            REG_VOLUMES: volumes_ff <= csr_wdata;
            REG_CHAN_EN: chan_en_ff <= csr_wdata[3:0];
            REG_MODE:    mode_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      chan3     = 3'(chan_ff);
      c2        = chan3[1:0];
      last_chan = (chan_ff == CH_W'(CHANNELS - 1));
      plays     = !chan3[2] && chan_en_ff[c2] && mode_ff[c2]
                  && !(c2 == 2'd1 && mode_ff[MODE_VOICE_MODE] && mode_ff[MODE_VOICE_EN])
                  && !(c2 == 2'd2 && mode_ff[MODE_SWEEP_MODE] && !mode_ff[MODE_SWEEP_KEEP]);
      nibble     = idx_ff[0] ? ram_rd_data[7:4] : ram_rd_data[3:0];
      value      = $signed({1'b0, nibble}) - 5'sd8;
      vol        = volumes_ff[{c2, 3'd4} +: 4];
      prod       = value * $signed({1'b0, vol});
      voice_term = $signed({{(ACC_W-9){1'b0}}, req_voice_sample, 1'b0}) - 12'sd256;
      hyper_term = $signed({{(ACC_W-9){1'b0}}, req_hyper_sample, 1'b0}) - 12'sd256;
      total      = $signed(acc_ff);
      total16    = 16'($signed(total));
   end

   assign ram_wr_en   = req_fire && (req_type == REQ_WRITE)
                        && ({1'b0, req_wave_addr[5:4]} < CHANNELS);
   assign ram_rd_en   = (state_ff == ST_READ);
   assign ram_rd_addr = AW'({chan3, idx_ff[IDX_W-1:1]});

   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      phase_in     = phase_ff;
      prev_in      = prev_ff;
      toggle_in    = toggle_ff;
      cnt_in       = cnt_ff;
      mixed_in     = mixed_ff;
      rsp_valid_in = rsp_valid_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {phase_ff[chan_ff], 8'd0};
      div_req.divisor  = PERIOD_BASE - {1'b0, freq_ff[c2]};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_type == REQ_TICK)) begin
               chan_in  = '0;
               acc_in   = ACC_W'(voice_term + hyper_term);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (plays) begin
               div_req.start = 1'b1;
               state_in      = ST_DIV;
            end else if (last_chan) begin
               state_in = ST_MIX;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               idx_in   = div_rsp.quot;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (idx_ff == '0 && prev_ff[chan_ff] != '0) begin
               phase_in[chan_ff] = PHASE_W'(1);
            end else begin
               phase_in[chan_ff] = phase_ff[chan_ff] + 1'b1;
            end
            prev_in[chan_ff] = idx_ff;
            acc_in = ACC_W'($signed(acc_ff) + ACC_W'(prod));
            if (last_chan) begin
               state_in = ST_MIX;
            end else begin
               chan_in  = chan_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_MIX: begin
            mixed_in     = (total16 << 5) + (total16 << 3);
            cnt_in       = toggle_ff ? 3'd4 : 3'd5;
            toggle_in    = !toggle_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (cnt_ff == 3'd1) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= '0;
         toggle_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            phase_ff[i] <= '0;
            prev_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         toggle_ff    <= toggle_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      acc_ff   <= acc_in;
      mixed_ff <= mixed_in;
   end

   fcwm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   fcwm_wave_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_wave_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(req_wave_addr)),
      .wr_data (req_wave_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mixed_sample = mixed_ff;
   assign rsp_last         = (cnt_ff == 3'd1);

   `FCWM_ASSERT_SAME(a_ready_excludes_output, clock, reset, req_ready, !rsp_valid)
   `FCWM_ASSERT_NEXT(a_copies_follow, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)
   `FCWM_ASSERT_NEXT(a_final_copy_frees, clock, reset, rsp_valid && rsp_ready && rsp_last, req_ready)
   `FCWM_ASSERT_NEXT(a_div_to_read, clock, reset, state_ff == ST_DIV && div_rsp.done, state_ff == ST_READ)

endmodule
`default_nettype wire

// ===== hdl/fcwm_div.sv =====
// Restoring divider, one quotient bit a cycle, returning the low quotient bits.
`default_nettype none
module fcwm_div import fcwm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   logic [DVD_W-1:0]  dvd_ff;
   logic [DIVR_W-1:0] divisor_ff;
   logic [DIVR_W-1:0] rem_ff;
   logic [IDX_W-1:0]  quot_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIVR_W:0]   shifted;
   logic [DIVR_W+1:0] diff;
   logic              take;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor_ff};
      take    = !diff[DIVR_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            dvd_ff     <= div_req.dividend;
            divisor_ff <= div_req.divisor;
            rem_ff     <= '0;
            cnt_ff     <= DCNT_W'(DVD_W - 1);
            busy_ff    <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= take ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            quot_ff <= {quot_ff[IDX_W-2:0], take};
            dvd_ff  <= {dvd_ff[DVD_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule
`default_nettype wire

// ===== hdl/fcwm_wave_ram.sv =====
// Wave RAM of sample pairs with per-row valid bits; unwritten rows read as mid-scale.
`default_nettype none
module fcwm_wave_ram import fcwm_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic       valid_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : WAVE_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== bench/mixer_sample_checker.sv =====
// Checker for the wavetable mixer: models the mixer and compares every result word with its prediction.
module mixer_sample_checker import fcwm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_type,
   input  logic [5:0]           req_wave_addr,
   input  logic [7:0]           req_wave_byte,
   input  logic [7:0]           req_voice_sample,
   input  logic [7:0]           req_hyper_sample,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [15:0]          rsp_mixed_sample,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   failures,
   output int                   pending,
   output int                   copies_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNELS      = 4;
   localparam int VOICE_CHANNEL = 1;
   localparam int SWEEP_CHANNEL = 2;
   localparam int WAVE_MID      = 8;
   localparam int PCM_SILENCE   = 128;
   localparam int MIX_GAIN      = 40;

   typedef struct {
      logic [15:0] sample;
      logic        last;
   } sample_copy_type;

   logic [FREQ_W-1:0]  freq_setting [CHANNELS];
   logic [31:0]        volume_bytes;
   logic [3:0]         sounding;
   logic [7:0]         mode_bits;
   logic [3:0]         wave_ram [CHANNELS*WAVE_STEPS];
   logic [PHASE_W-1:0] phase [CHANNELS];
   logic [IDX_W-1:0]   prev_index [CHANNELS];
   logic               four_copies;
   sample_copy_type    expected_copies [$];
   sample_copy_type    oldest;

   initial begin
      failures       = 0;
      pending        = 0;
      copies_checked = 0;
   end

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      $display("at %0t: %s: expected %h, got %h", $time, what, want, got);
      failures++;
   endtask

   task automatic clear_model();
      for (int c = 0; c < CHANNELS; c++) begin
         freq_setting[c] = '0;
         phase[c]        = '0;
         prev_index[c]   = '0;
      end
      for (int i = 0; i < CHANNELS * WAVE_STEPS; i++) begin
         wave_ram[i] = WAVE_RESET[3:0];
      end
      volume_bytes = '0;
      sounding     = '0;
      mode_bits    = MODE_RESET;
      four_copies  = 1'b0;
      expected_copies.delete();
   endtask

   function automatic bit channel_sounds(input int c);
      if (!sounding[c] || !mode_bits[c]) return 1'b0;
      if (c == VOICE_CHANNEL && mode_bits[MODE_VOICE_MODE] && mode_bits[MODE_VOICE_EN])
         return 1'b0;
      if (c == SWEEP_CHANNEL && mode_bits[MODE_SWEEP_MODE] && !mode_bits[MODE_SWEEP_KEEP])
         return 1'b0;
      return 1'b1;
   endfunction

   task automatic store_wave_byte(input logic [5:0] addr, input logic [7:0] wbyte);
      int row;
      row = addr[5:4] * WAVE_STEPS + addr[3:0] * 2;
      wave_ram[row]     = wbyte[3:0];
      wave_ram[row + 1] = wbyte[7:4];
   endtask

   task automatic predict_mixed_sample(input logic [7:0] voice, input logic [7:0] hyper);
      int               sum;
      int               copies;
      longint unsigned  scaled;
      logic [IDX_W-1:0] idx;
      logic [3:0]       vol;
      sample_copy_type  copy;
      sum = 0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (channel_sounds(c)) begin
            scaled = (64'(phase[c]) << 8) / 64'(PERIOD_BASE - freq_setting[c]);
            idx = scaled[IDX_W-1:0];
            // The phase restarts when the index wraps back to the start of the wave.
            if (idx == 0 && prev_index[c] != 0) phase[c] = '0;
            prev_index[c] = idx;
            phase[c] = phase[c] + 1'b1;
            vol = volume_bytes[8*c+4 +: 4];
            sum += (int'(wave_ram[c * WAVE_STEPS + idx]) - WAVE_MID) * int'(vol);
         end
      end
      sum += (int'(voice) - PCM_SILENCE) * 2;
      sum += (int'(hyper) - PCM_SILENCE) * 2;
      sum *= MIX_GAIN;
      copies = four_copies ? 4 : 5;
      four_copies = ~four_copies;
      for (int k = 0; k < copies; k++) begin
         copy.sample = sum[15:0];
         copy.last   = (k == copies - 1);
         expected_copies.push_back(copy);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FREQ0:   freq_setting[0] = csr_wdata[FREQ_W-1:0];
               REG_FREQ1:   freq_setting[1] = csr_wdata[FREQ_W-1:0];
               REG_FREQ2:   freq_setting[2] = csr_wdata[FREQ_W-1:0];
               REG_FREQ3:   freq_setting[3] = csr_wdata[FREQ_W-1:0];
               REG_VOLUMES: volume_bytes    = csr_wdata;
               REG_CHAN_EN: sounding        = csr_wdata[3:0];
               REG_MODE:    mode_bits       = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_copies.size() == 0) begin
               report_mismatch("result word with nothing expected", '0, rsp_mixed_sample);
            end else begin
               oldest = expected_copies.pop_front();
               copies_checked++;
               if (rsp_mixed_sample !== oldest.sample)
                  report_mismatch("mixed sample", oldest.sample, rsp_mixed_sample);
               if (rsp_last !== oldest.last)
                  report_mismatch("last flag", 16'(oldest.last), 16'(rsp_last));
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == REQ_WRITE) begin
               store_wave_byte(req_wave_addr, req_wave_byte);
            end else begin
               predict_mixed_sample(req_voice_sample, req_hyper_sample);
            end
         end
      end
      pending = expected_copies.size();
   end

endmodule

// ===== bench/four_channel_wavetable_mixer_unit_tb.sv =====
// Testbench top for the wavetable mixer: drives words and register writes and gives the verdict.
module four_channel_wavetable_mixer_unit_tb
   import fcwm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 8;
   localparam int TICK_CYCLES   = 160;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_WORDS   = 40;
   localparam int REG_COUNT     = 7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_type;
   logic [5:0]           req_wave_addr;
   logic [7:0]           req_wave_byte;
   logic [7:0]           req_voice_sample;
   logic [7:0]           req_hyper_sample;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [15:0]          rsp_mixed_sample;
   logic                 rsp_last;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;
   int                   failures;
   int                   pending;
   int                   copies_checked;

   bit tx_idling;
   bit rx_idling;
   bit hold_go;
   int writes_sent;
   int ticks_sent;
   int settings_used;

   four_channel_wavetable_mixer_unit dut (.*);

   mixer_sample_checker sample_check (.*);

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timed out waiting for the mixer");
      $display("simulation failed");
      $finish;
   end

   // Result side: random stalls, and one long hold-off so that the mixer backs up.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_go = 1'b0;
            rsp_ready <= 1'b1;
         end else if (rx_idling && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_word(input logic kind, input logic [5:0] addr, input logic [7:0] wbyte,
                            input logic [7:0] voice, input logic [7:0] hyper);
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_wave_addr    <= addr;
      req_wave_byte    <= wbyte;
      req_voice_sample <= voice;
      req_hyper_sample <= hyper;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (kind == REQ_TICK) ticks_sent++;
      else writes_sent++;
   endtask

   task automatic sender_gap();
      if (tx_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
      return ($urandom << width) | value;
   endfunction

   task automatic program_mixer(input logic [FREQ_W-1:0] f0, input logic [FREQ_W-1:0] f1,
                                input logic [FREQ_W-1:0] f2, input logic [FREQ_W-1:0] f3,
                                input logic [31:0] vol, input logic [3:0] en,
                                input logic [7:0] mode);
      logic [CSR_IDX_W-1:0] idx [REG_COUNT];
      logic [31:0]          data [REG_COUNT];
      wait_idle();
      idx  = '{REG_FREQ0, REG_FREQ1, REG_FREQ2, REG_FREQ3, REG_VOLUMES, REG_CHAN_EN, REG_MODE};
      data = '{with_junk(32'(f0), FREQ_W), with_junk(32'(f1), FREQ_W),
               with_junk(32'(f2), FREQ_W), with_junk(32'(f3), FREQ_W),
               vol, with_junk(32'(en), 4), with_junk(32'(mode), 8)};
      for (int r = 0; r < REG_COUNT; r++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[r];
         csr_wdata <= data[r];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [FREQ_W-1:0] pick_freq();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return FREQ_W'($urandom);
         default: return FREQ_W'($urandom_range(1950, 2046));
      endcase
   endfunction

   function automatic logic [7:0] pick_mode();
      if ($urandom_range(0, 1)) return {4'($urandom), 4'hF};
      return 8'($urandom);
   endfunction

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_WRITE;
      req_wave_addr    = '0;
      req_wave_byte    = '0;
      req_voice_sample = '0;
      req_hyper_sample = '0;
      csr_valid        = 1'b0;
      csr_index        = REG_FREQ0;
      csr_wdata        = '0;
      tx_idling        = 1'b0;
      rx_idling        = 1'b0;
      hold_go          = 1'b0;
      writes_sent      = 0;
      ticks_sent       = 0;
      settings_used    = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // With the reset settings every channel is silent and only the voice and hyper bytes are heard.
      send_word(REQ_TICK, 6'h00, 8'h00, 8'h00, 8'h00);
      send_word(REQ_TICK, 6'h3F, 8'hFF, 8'hFF, 8'hFF);
      send_word(REQ_TICK, 6'h15, 8'hA5, 8'h80, 8'h80);
      send_word(REQ_WRITE, 6'h00, 8'hF0, 8'h00, 8'h00);
      send_word(REQ_WRITE, 6'h3F, 8'h0F, 8'hFF, 8'hFF);

      // All channels stuck on the first sample at full volume, to wrap the sum both ways.
      program_mixer('1, '1, '1, '1, '1, 4'hF, 8'h0F);
      send_word(REQ_WRITE, 6'h00, 8'h0F, 8'h00, 8'h00);
      send_word(REQ_WRITE, 6'h10, 8'h0F, 8'h00, 8'h00);
      send_word(REQ_WRITE, 6'h20, 8'h0F, 8'h00, 8'h00);
      send_word(REQ_WRITE, 6'h30, 8'h0F, 8'h00, 8'h00);
      send_word(REQ_TICK, 6'h00, 8'h00, 8'hFF, 8'hFF);
      send_word(REQ_WRITE, 6'h00, 8'hF0, 8'h00, 8'h00);
      send_word(REQ_WRITE, 6'h10, 8'hF0, 8'h00, 8'h00);
      send_word(REQ_WRITE, 6'h20, 8'hF0, 8'h00, 8'h00);
      send_word(REQ_WRITE, 6'h30, 8'hF0, 8'h00, 8'h00);
      send_word(REQ_TICK, 6'h00, 8'h00, 8'h00, 8'h00);

      // Voice mode silences channel 1 and sweep mode without keep silences channel 2.
      program_mixer('0, 11'd1792, 11'd2040, 11'd2046, 32'hA5C3_7E19, 4'hF, 8'hDF);
      for (int n = 0; n < 3; n++) begin
         send_word(REQ_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end

      // Channel 2 switched off and channel 3 without its user enable.
      program_mixer(11'd1900, 11'd2000, 11'd1024, 11'd2047, 32'h3CF0_96E7, 4'b1011, 8'hB7);
      for (int n = 0; n < 3; n++) begin
         send_word(REQ_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            program_mixer('1, '1, '1, '1, '1, 4'hF, 8'hFF);
         end else if (p == 1) begin
            program_mixer(pick_freq(), pick_freq(), pick_freq(), pick_freq(), '0, '0, '0);
         end else begin
            program_mixer(pick_freq(), pick_freq(), pick_freq(), pick_freq(), $urandom,
                          $urandom_range(0, 2) != 0 ? 4'hF : 4'($urandom), pick_mode());
         end
         tx_idling = (p != RANDOM_PHASES - 1) && $urandom_range(0, 3) != 0;
         rx_idling = (p != RANDOM_PHASES - 1) && $urandom_range(0, 3) != 0;
         for (int w = 0; w < PHASE_WORDS; w++) begin
            if (p == 2 && w == PHASE_WORDS / 4) hold_go = 1'b1;
            if ($urandom_range(0, 9) < 3) begin
               send_word(REQ_WRITE, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
               send_word(REQ_TICK, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            sender_gap();
         end
      end

      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(negedge clock);
      repeat (TICK_CYCLES) @(negedge clock);
      $display("covered %0d wave writes and %0d ticks under %0d register settings",
               writes_sent, ticks_sent, settings_used);
      $display("checked %0d sample words, %0d expected words left over", copies_checked, pending);
      if (failures == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fcwm_pkg.sv
hdl/fcwm_div.sv
hdl/fcwm_wave_ram.sv
hdl/four_channel_wavetable_mixer_unit.sv
bench/mixer_sample_checker.sv
bench/four_channel_wavetable_mixer_unit_tb.sv
